// ===== rtl/fqmtf_pkg.sv =====
// shared types and constants for the fifo queue with move-to-front
// holds action codes, field widths and the controller/datapath command and status structs
// no dependencies
`default_nettype none

package fqmtf_pkg;

    localparam int ACTION_W       = 2;
    localparam int VALUE_W        = 16;
    localparam int TIME_W         = 32;
    localparam int COUNT_W        = 5;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_TIME_WIDTH = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ   = 2'd0,
        ACT_DEQ   = 2'd1,
        ACT_MTF   = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_PREV,
        RD_HEAD
    } t_rd_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_HEAD_WR,
        ST_FRONT_RD,
        ST_FRONT_LD
    } t_state;

    typedef struct packed {
        logic    load_item;
        logic    enq_wr;
        logic    deq;
        logic    set_err;
        logic    set_found;
        logic    take_match;
        logic    inc_k;
        logic    dec_k;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_shift;
        logic    wr_head;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    full;
        logic    empty;
        logic    match;
        logic    k_zero;
        logic    k_one;
        logic    k_last;
        logic    out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/fqmtf_ctrl.sv =====
// controller state machine: sequences each action over the datapath
// depends on fqmtf_pkg for the state enum and the command/status structs
`default_nettype none

module fqmtf_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire fqmtf_pkg::t_dp_status i_status,
    output fqmtf_pkg::t_dp_cmd     o_cmd
);
    import fqmtf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.rd_sel = RD_HEAD;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_status.action)
                    ACT_ENQ: begin
                        if (i_status.full) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            o_cmd.enq_wr = 1'b1;
                        end
                        n_state = ST_FRONT_RD;
                    end
                    ACT_DEQ: begin
                        if (i_status.empty) begin
                            o_cmd.set_err = 1'b1;
                        end else begin
                            o_cmd.deq = 1'b1;
                        end
                        n_state = ST_FRONT_RD;
                    end
                    ACT_MTF: begin
                        n_state = i_status.empty ? ST_FRONT_RD : ST_SCAN_RD;
                    end
                    ACT_QUERY: begin
                        n_state = ST_FRONT_RD;
                    end
                endcase
            end
            ST_SCAN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SCAN;
                n_state = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (i_status.match) begin
                    o_cmd.set_found  = 1'b1;
                    o_cmd.take_match = 1'b1;
                    // already at the front: order is unchanged
                    n_state = i_status.k_zero ? ST_FRONT_RD : ST_SHIFT_RD;
                end else if (i_status.k_last) begin
                    n_state = ST_FRONT_RD;
                end else begin
                    o_cmd.inc_k = 1'b1;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_PREV;
                n_state = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.dec_k    = 1'b1;
                n_state = i_status.k_one ? ST_HEAD_WR : ST_SHIFT_RD;
            end
            ST_HEAD_WR: begin
                o_cmd.wr_head = 1'b1;
                n_state = ST_FRONT_RD;
            end
            ST_FRONT_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_HEAD;
                n_state = ST_FRONT_LD;
            end
            ST_FRONT_LD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_front_ld_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FRONT_LD && i_status.out_free) |=> (r_state == ST_IDLE))
        else $error("result loaded but controller did not return to idle");

    a_dec_k_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.dec_k |-> !i_status.k_zero)
        else $error("shift index stepped below zero");

    a_shift_after_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_CMP && n_state == ST_SHIFT_RD) |-> i_status.match)
        else $error("shift started without a match");
`endif

endmodule

`default_nettype wire

// ===== rtl/fqmtf_dp.sv =====
// datapath: circular entry memory, head pointer, count, scan index and result register
// depends on fqmtf_pkg for field widths and the command/status structs
`default_nettype none

module fqmtf_dp #(
    parameter int DEPTH      = fqmtf_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = fqmtf_pkg::DEF_DATA_WIDTH,
    parameter int TIME_WIDTH = fqmtf_pkg::DEF_TIME_WIDTH
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire fqmtf_pkg::t_dp_cmd              i_cmd,
    output fqmtf_pkg::t_dp_status                o_status,
    input  wire [fqmtf_pkg::ACTION_W-1:0]        i_action,
    input  wire [fqmtf_pkg::VALUE_W-1:0]         i_value,
    input  wire [fqmtf_pkg::TIME_W-1:0]          i_start_time,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [fqmtf_pkg::VALUE_W-1:0]        o_front_value,
    output logic [fqmtf_pkg::TIME_W-1:0]         o_front_time,
    output logic [fqmtf_pkg::COUNT_W-1:0]        o_entry_count,
    output logic                                 o_is_empty,
    output logic                                 o_found,
    output logic                                 o_error
);
    import fqmtf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // head plus offset, wrapped around the ring
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        begin
            sum = {1'b0, base} + {1'b0, off};
            if (sum >= DEPTH_A) begin
                sum = sum - DEPTH_A;
            end
            wrap_add = sum[AW-1:0];
        end
    endfunction

    logic [DATA_WIDTH-1:0] r_mem_value [DEPTH];
    logic [TIME_WIDTH-1:0] r_mem_time  [DEPTH];

    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_k;
    t_action               r_action;
    logic [DATA_WIDTH-1:0] r_item_value;
    logic [TIME_WIDTH-1:0] r_item_time;
    logic [DATA_WIDTH-1:0] r_rd_value;
    logic [TIME_WIDTH-1:0] r_rd_time;
    logic [DATA_WIDTH-1:0] r_mv_value;
    logic [TIME_WIDTH-1:0] r_mv_time;
    logic                  r_found;
    logic                  r_err;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    logic [TIME_W-1:0]     r_out_time;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_empty;
    logic                  r_out_found;
    logic                  r_out_err;

    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] wr_value;
    logic [TIME_WIDTH-1:0] wr_time;
    logic                  out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_SCAN: rd_addr = wrap_add(r_head, r_k);
            RD_PREV: rd_addr = wrap_add(r_head, r_k - AW'(1));
            default: rd_addr = r_head;
        endcase
    end

    always_comb begin
        wr_en    = i_cmd.enq_wr || i_cmd.wr_shift || i_cmd.wr_head;
        wr_addr  = r_head;
        wr_value = r_mv_value;
        wr_time  = r_mv_time;
        if (i_cmd.enq_wr) begin
            // tail slot; count is below depth here
            wr_addr  = wrap_add(r_head, r_count[AW-1:0]);
            wr_value = r_item_value;
            wr_time  = r_item_time;
        end else if (i_cmd.wr_shift) begin
            wr_addr  = wrap_add(r_head, r_k);
            wr_value = r_rd_value;
            wr_time  = r_rd_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_value[wr_addr] <= wr_value;
            r_mem_time[wr_addr]  <= wr_time;
        end
        if (i_cmd.rd_en) begin
            r_rd_value <= r_mem_value[rd_addr];
            r_rd_time  <= r_mem_time[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.enq_wr) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.deq) begin
                r_count <= r_count - CW'(1);
                r_head  <= wrap_add(r_head, AW'(1));
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action     <= t_action'(i_action);
            r_item_value <= DATA_WIDTH'(i_value);
            r_item_time  <= TIME_WIDTH'(i_start_time);
            r_k          <= '0;
            r_found      <= 1'b0;
            r_err        <= 1'b0;
        end else begin
            if (i_cmd.inc_k) begin
                r_k <= r_k + AW'(1);
            end else if (i_cmd.dec_k) begin
                r_k <= r_k - AW'(1);
            end
            if (i_cmd.set_err) begin
                r_err <= 1'b1;
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
        end
        if (i_cmd.take_match) begin
            r_mv_value <= r_rd_value;
            r_mv_time  <= r_rd_time;
        end
        if (i_cmd.load_out) begin
            r_out_value <= (r_count == '0) ? '0 : VALUE_W'(r_rd_value);
            r_out_time  <= (r_count == '0) ? '0 : TIME_W'(r_rd_time);
            r_out_count <= COUNT_W'(r_count);
            r_out_empty <= (r_count == '0);
            r_out_found <= r_found;
            r_out_err   <= r_err;
        end
    end

    always_comb begin
        o_status.action   = r_action;
        o_status.full     = (r_count == DEPTH_C);
        o_status.empty    = (r_count == '0);
        o_status.match    = (r_rd_value == r_item_value);
        o_status.k_zero   = (r_k == '0);
        o_status.k_one    = (r_k == AW'(1));
        o_status.k_last   = ((CW'(r_k) + CW'(1)) == r_count);
        o_status.out_free = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_out_value;
    assign o_front_time  = r_out_time;
    assign o_entry_count = r_out_count;
    assign o_is_empty    = r_out_empty;
    assign o_found       = r_out_found;
    assign o_error       = r_out_err;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above depth");

    a_enq_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enq_wr |-> (r_count != DEPTH_C))
        else $error("write at tail while full");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.deq |=> (r_count == $past(r_count) - CW'(1)))
        else $error("dequeue did not lower the count by one");
`endif

endmodule

`default_nettype wire

// ===== rtl/fifo_queue_with_move_to_front.sv =====
// top level of the bounded fifo of value/start-time pairs with move-to-front
// instantiates fqmtf_ctrl and fqmtf_dp; depends on fqmtf_pkg
`default_nettype none

// Bounded queue of (value, start time) pairs kept in a ring memory of DEPTH
// entries. Each item carries one action (enqueue, dequeue, move first matching value to
// the front, query) and returns one result describing the queue afterwards. One item is
// in work at a time: enqueue, dequeue and query pass through execute, front read and
// result load; move-to-front reads and compares one entry at a time while scanning from
// the front and, on a match not at the front, moves each entry ahead of it back one slot
// by a read and a write, then writes the match at the head. The memory has one
// registered read port. A finished result waits in an output register while the next
// item is taken. entry_count reports the low 5 bits of the occupancy.
module fifo_queue_with_move_to_front #(
    parameter int DEPTH      = fqmtf_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = fqmtf_pkg::DEF_DATA_WIDTH,
    parameter int TIME_WIDTH = fqmtf_pkg::DEF_TIME_WIDTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [fqmtf_pkg::ACTION_W-1:0]    i_action,
    input  wire [fqmtf_pkg::VALUE_W-1:0]     i_value,
    input  wire [fqmtf_pkg::TIME_W-1:0]      i_start_time,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [fqmtf_pkg::VALUE_W-1:0]    o_front_value,
    output logic [fqmtf_pkg::TIME_W-1:0]     o_front_time,
    output logic [fqmtf_pkg::COUNT_W-1:0]    o_entry_count,
    output logic                             o_is_empty,
    output logic                             o_found,
    output logic                             o_error
);
    import fqmtf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    fqmtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fqmtf_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_start_time  (i_start_time),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_front_value (o_front_value),
        .o_front_time  (o_front_time),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_found       (o_found),
        .o_error       (o_error)
    );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking bench for fifo_queue_with_move_to_front: a queue-based driver and a
// monitor that checks every result against a cycle-free queue predictor
// depends on fqmtf_pkg and the rtl top level
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fqmtf_pkg::*;

    localparam int QDEPTH       = DEF_DEPTH;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_action            action;
        logic [VALUE_W-1:0] value;
        logic [TIME_W-1:0]  start_time;
    } queue_item;

    typedef struct packed {
        logic [VALUE_W-1:0] front_value;
        logic [TIME_W-1:0]  front_time;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic               found;
        logic               error;
    } queue_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic [ACTION_W-1:0] i_action = '0;
    logic [VALUE_W-1:0]  i_value = '0;
    logic [TIME_W-1:0]   i_start_time = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [VALUE_W-1:0]  o_front_value;
    logic [TIME_W-1:0]   o_front_time;
    logic [COUNT_W-1:0]  o_entry_count;
    logic                o_is_empty;
    logic                o_found;
    logic                o_error;

    fifo_queue_with_move_to_front dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_start_time  (i_start_time),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_front_value (o_front_value),
        .o_front_time  (o_front_time),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_found       (o_found),
        .o_error       (o_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    queue_item   items_to_send[$];
    queue_result results_due[$];

    // predicted queue contents, entry 0 is the front
    logic [VALUE_W-1:0] model_values[QDEPTH];
    logic [TIME_W-1:0]  model_times[QDEPTH];
    int                 model_count = 0;

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  hold_left = 0;
    bit  hold_req = 1'b0;
    bit  in_taken = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count = 0;

    function automatic queue_result queue_step(queue_item it);
        queue_result        r;
        int                 i;
        int                 hit;
        logic [VALUE_W-1:0] mv;
        logic [TIME_W-1:0]  mt;
        r = '0;
        case (it.action)
            ACT_ENQ: begin
                if (model_count >= QDEPTH) begin
                    r.error = 1'b1;
                end else begin
                    model_values[model_count] = it.value;
                    model_times[model_count] = it.start_time;
                    model_count++;
                end
            end
            ACT_DEQ: begin
                if (model_count == 0) begin
                    r.error = 1'b1;
                end else begin
                    for (i = 1; i < model_count; i++) begin
                        model_values[i-1] = model_values[i];
                        model_times[i-1] = model_times[i];
                    end
                    model_count--;
                end
            end
            ACT_MTF: begin
                hit = -1;
                for (i = 0; i < model_count; i++) begin
                    if (hit < 0 && model_values[i] == it.value)
                        hit = i;
                end
                if (hit >= 0) begin
                    r.found = 1'b1;
                    mv = model_values[hit];
                    mt = model_times[hit];
                    for (i = hit; i > 0; i--) begin
                        model_values[i] = model_values[i-1];
                        model_times[i] = model_times[i-1];
                    end
                    model_values[0] = mv;
                    model_times[0] = mt;
                end
            end
            default: ;
        endcase
        if (model_count != 0) begin
            r.front_value = model_values[0];
            r.front_time = model_times[0];
        end
        r.entry_count = COUNT_W'(model_count);
        r.is_empty = (model_count == 0);
        return r;
    endfunction

    // input side: predict on every accepted item
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            results_due.push_back(queue_step('{t_action'(i_action), i_value, i_start_time}));
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (items_to_send.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                queue_item it;
                it = items_to_send.pop_front();
                i_in_valid <= 1'b1;
                i_action <= it.action;
                i_value <= it.value;
                i_start_time <= it.start_time;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
            if (hold_req)
                hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge i_clk) begin
        queue_result want;
        queue_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_front_value, o_front_time, o_entry_count, o_is_empty, o_found, o_error};
            if (results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result with nothing pending: front %h/%h count %0d",
                             got.front_value, got.front_time, got.entry_count);
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: front_value %h/%h front_time %h/%h ",
                                  "count %0d/%0d empty %b/%b found %b/%b error %b/%b"},
                                 want.front_value, got.front_value,
                                 want.front_time, got.front_time,
                                 want.entry_count, got.entry_count,
                                 want.is_empty, got.is_empty, want.found, got.found,
                                 want.error, got.error);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[fifo_queue_with_move_to_front] ERROR");
            $finish;
        end
    end

    task automatic send(t_action act, logic [VALUE_W-1:0] v, logic [TIME_W-1:0] t);
        items_to_send.push_back('{act, v, t});
    endtask

    // enqueue weight swings between filling and draining so full and empty both occur
    task automatic send_random(int n);
        int                 enq_w;
        int                 r;
        int                 j;
        t_action            act;
        logic [VALUE_W-1:0] v;
        enq_w = 55;
        for (j = 0; j < n; j++) begin
            if (j % 40 == 0)
                enq_w = ($urandom_range(1, 0) != 0) ? 55 : 15;
            r = $urandom_range(99, 0);
            if (r < enq_w)
                act = ACT_ENQ;
            else if (r < enq_w + 30)
                act = ACT_MTF;
            else if (r < enq_w + 35)
                act = ACT_QUERY;
            else
                act = ACT_DEQ;
            // a small value set gives duplicates and frequent matches
            v = ($urandom_range(99, 0) < 70) ? VALUE_W'($urandom_range(7, 0))
                                             : VALUE_W'($urandom);
            send(act, v, $urandom);
        end
    endtask

    task automatic wait_sent();
        while (items_to_send.size() != 0 || i_in_valid)
            @(posedge i_clk);
    endtask

    initial begin
        int j;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 25;
        rx_idle_pct = 68;
        // empty-queue cases
        send(ACT_QUERY, 16'h0000, 32'h0000_0000);
        send(ACT_DEQ, 16'hffff, 32'hffff_ffff);
        send(ACT_MTF, 16'h0000, 32'h0000_0000);
        // fill to the brim, extremes first
        send(ACT_ENQ, 16'h0000, 32'h0000_0000);
        send(ACT_ENQ, 16'hffff, 32'hffff_ffff);
        for (j = 2; j < QDEPTH; j++)
            send(ACT_ENQ, VALUE_W'(16'h5a00 + j), $urandom);
        send(ACT_ENQ, 16'h1234, 32'h8000_0001);
        send(ACT_MTF, 16'hffff, $urandom);
        send(ACT_MTF, VALUE_W'(16'h5a00 + QDEPTH - 1), $urandom);
        send(ACT_MTF, 16'h1234, $urandom);
        // match already at the front
        send(ACT_MTF, VALUE_W'(16'h5a00 + QDEPTH - 1), $urandom);
        send(ACT_DEQ, 16'h0000, 32'h0000_0000);
        send(ACT_QUERY, 16'hffff, 32'hffff_ffff);
        send_random(330);
        wait_sent();

        tx_idle_pct = 68;
        rx_idle_pct = 25;
        send_random(350);
        wait_sent();

        // long receiver hold-off while the sender keeps offering
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        while (hold_left == 0)
            @(posedge i_clk);
        hold_req = 1'b0;
        send_random(60);
        wait_sent();

        send_random(300);
        wait_sent();

        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[fifo_queue_with_move_to_front] OK");
        else
            $display("[fifo_queue_with_move_to_front] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== fifo_queue_with_move_to_front.f =====
rtl/fqmtf_pkg.sv
rtl/fqmtf_ctrl.sv
rtl/fqmtf_dp.sv
rtl/fifo_queue_with_move_to_front.sv
sim/testbench.sv
